FILE: src/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
// Used by wsfd_parser, wsfd_result_fifo and websocket_frame_decoder.
`default_nettype none

package wsfd_pkg;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [2:0]  frame_class;
        logic [15:0] payload_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic t_result make_result(input t_kind kind, input logic [7:0] pb,
                                            input logic [2:0] cls, input logic [15:0] len);
        t_result r;
        r.kind           = kind;
        r.payload_byte   = pb;
        r.frame_class    = cls;
        r.payload_length = len;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/wsfd_parser.sv
// Frame header parser, unmasking and result generation for one byte per cycle while i_accept is high.
// Depends on wsfd_pkg for the result types.
`default_nettype none

module wsfd_parser
    import wsfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_end,
    input  wire logic [16:0] i_cap,
    output t_push            o_push
);

    typedef enum logic [6:0] {
        PH_HDR0  = 7'b0000001,
        PH_HDR1  = 7'b0000010,
        PH_EXT16 = 7'b0000100,
        PH_EXT64 = 7'b0001000,
        PH_MASK  = 7'b0010000,
        PH_DATA  = 7'b0100000,
        PH_DRAIN = 7'b1000000
    } t_phase;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [2:0] CLS_CONT  = 3'd0;
    localparam logic [2:0] CLS_TEXT  = 3'd1;
    localparam logic [2:0] CLS_BIN   = 3'd2;
    localparam logic [2:0] CLS_CLOSE = 3'd3;
    localparam logic [2:0] CLS_PING  = 3'd4;
    localparam logic [2:0] CLS_PONG  = 3'd5;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_ext, n_ext;
    logic [15:0] r_len, n_len;
    logic        r_big, n_big;
    logic [31:0] r_key, n_key;
    logic        r_mask_on, n_mask_on;
    logic [15:0] r_count, n_count;
    logic [2:0]  r_class, n_class;

    logic        ok;
    logic [2:0]  cls;
    logic        len_known;
    logic        hdr_done;
    logic        err_now;
    logic [4:0]  key_sh;
    logic [7:0]  plain;
    logic        v0, v1;
    t_result     res0, res1;

    always_comb begin
        n_phase   = r_phase;
        n_ext     = r_ext;
        n_len     = r_len;
        n_big     = r_big;
        n_key     = r_key;
        n_mask_on = r_mask_on;
        n_count   = r_count;
        n_class   = r_class;
        ok        = 1'b1;
        cls       = CLS_CONT;
        len_known = 1'b0;
        hdr_done  = 1'b0;
        err_now   = 1'b0;
        key_sh    = {~r_count[1:0], 3'b000};
        plain     = i_byte ^ (r_mask_on ? r_key[key_sh +: 8] : 8'h00);
        v0        = 1'b0;
        v1        = 1'b0;
        res0      = '0;
        res1      = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HDR0: begin
                    if (i_byte[7]) begin
                        unique case (i_byte[3:0])
                            OP_TEXT:  cls = CLS_TEXT;
                            OP_BIN:   cls = CLS_BIN;
                            OP_CLOSE: cls = CLS_CLOSE;
                            OP_PING:  cls = CLS_PING;
                            OP_PONG:  cls = CLS_PONG;
                            default:  ok = 1'b0;
                        endcase
                    end else if (i_byte[3:0] != OP_CONT) begin
                        ok = 1'b0;
                    end
                    n_ext     = '0;
                    n_len     = '0;
                    n_big     = 1'b0;
                    n_key     = '0;
                    n_mask_on = 1'b0;
                    n_count   = '0;
                    if (ok) begin
                        n_class = cls;
                        n_phase = PH_HDR1;
                    end else begin
                        err_now = 1'b1;
                    end
                end
                PH_HDR1: begin
                    n_mask_on = i_byte[7];
                    n_ext     = '0;
                    n_len     = '0;
                    n_big     = 1'b0;
                    if (i_byte[6:0] == LEN_EXT16) begin
                        n_phase = PH_EXT16;
                    end else if (i_byte[6:0] == LEN_EXT64) begin
                        n_phase = PH_EXT64;
                    end else begin
                        n_len     = {9'd0, i_byte[6:0]};
                        len_known = 1'b1;
                    end
                end
                PH_EXT16: begin
                    n_len = {r_len[7:0], i_byte};
                    if (r_ext >= 3'd1) begin
                        len_known = 1'b1;
                    end else begin
                        n_ext = r_ext + 3'd1;
                    end
                end
                PH_EXT64: begin
                    if (r_ext < 3'd4 && i_byte != 8'h00) begin
                        err_now = 1'b1;
                    end else begin
                        if (r_ext >= 3'd4) begin
                            n_len = {r_len[7:0], i_byte};
                            if ((r_ext == 3'd4 || r_ext == 3'd5) && i_byte != 8'h00) begin
                                n_big = 1'b1;
                            end
                        end
                        if (r_ext >= 3'd7) begin
                            len_known = 1'b1;
                        end else begin
                            n_ext = r_ext + 3'd1;
                        end
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    if (r_ext >= 3'd3) begin
                        hdr_done = 1'b1;
                    end else begin
                        n_ext = r_ext + 3'd1;
                    end
                end
                PH_DATA: begin
                    v0      = 1'b1;
                    res0    = make_result(KIND_PAYLOAD, plain, r_class, 16'd0);
                    n_count = r_count + 16'd1;
                    if (n_count >= r_len) begin
                        n_phase = PH_DRAIN;
                        v1      = 1'b1;
                        res1    = make_result(KIND_DONE, 8'h00, r_class, r_len);
                    end
                end
                PH_DRAIN: begin
                    n_phase = PH_DRAIN;
                end
                default: begin
                    n_phase = PH_DRAIN;
                end
            endcase

            if (len_known) begin
                if (n_big || ({1'b0, n_len} + 17'd1 > i_cap)) begin
                    err_now = 1'b1;
                end else if (n_mask_on) begin
                    n_phase = PH_MASK;
                    n_ext   = '0;
                    n_key   = '0;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                if (n_len == 16'd0) begin
                    n_phase = PH_DRAIN;
                    v0      = 1'b1;
                    res0    = make_result(KIND_DONE, 8'h00, r_class, 16'd0);
                end else begin
                    n_phase = PH_DATA;
                    n_count = '0;
                end
            end

            if (err_now) begin
                n_phase = PH_DRAIN;
                v0      = 1'b1;
                res0    = make_result(KIND_ERROR, 8'h00, CLS_CONT, 16'd0);
            end

            if (i_end) begin
                if (n_phase != PH_DRAIN) begin
                    if (v0) begin
                        v1   = 1'b1;
                        res1 = make_result(KIND_ERROR, 8'h00, CLS_CONT, 16'd0);
                    end else begin
                        v0   = 1'b1;
                        res0 = make_result(KIND_ERROR, 8'h00, CLS_CONT, 16'd0);
                    end
                end
                n_phase = PH_HDR0;
            end
        end

        res0.last = v0 && !v1;
        res1.last = v1;
        o_push.num  = {v1, v0 && !v1};
        o_push.res0 = res0;
        o_push.res1 = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_ext     <= '0;
            r_len     <= '0;
            r_big     <= 1'b0;
            r_key     <= '0;
            r_mask_on <= 1'b0;
            r_count   <= '0;
            r_class   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_ext     <= n_ext;
            r_len     <= n_len;
            r_big     <= n_big;
            r_key     <= n_key;
            r_mask_on <= n_mask_on;
            r_count   <= n_count;
            r_class   <= n_class;
        end
    end

endmodule

`default_nettype wire

FILE: src/wsfd_result_fifo.sv
// Small result queue that takes up to two results per cycle and sends one per cycle while i_ready is high.
// Depends on wsfd_pkg for the result types and the queue depth.
`default_nettype none

module wsfd_result_fifo
    import wsfd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_space,
    output logic       o_valid,
    output t_result    o_data,
    input  wire logic  i_ready
);

    t_result                r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr;
    logic [RES_CNT_W-1:0]   r_count;
    logic [RES_PTR_W-1:0]   wr_ptr1;
    logic                   pop;

    assign wr_ptr1 = r_wr_ptr + RES_PTR_W'(1);
    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_space = (r_count <= RES_CNT_W'(RES_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_PTR_W'(i_push.num);
            r_rd_ptr <= r_rd_ptr + RES_PTR_W'(pop);
            r_count  <= r_count + RES_CNT_W'(i_push.num) - RES_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_CNT_W'(RES_DEPTH))
        else $error("Result queue holds more entries than its depth.");

    a_push_with_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_space)
        else $error("Results pushed while the queue lacks room for two.");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num == 2'd1) |-> i_push.res0.last)
        else $error("A lone result of a transaction is not marked last.");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num == 2'd2) |-> (!i_push.res0.last && i_push.res1.last))
        else $error("A result pair is not marked last on its second entry only.");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && i_push.num == 2'd0) |=> r_count == $past(r_count))
        else $error("Queue count changed without a push or a pop.");
`endif

endmodule

`default_nettype wire

FILE: src/websocket_frame_decoder.sv
// WebSocket frame decoder: one received byte per input transaction.
// The slave stream carries a byte in s_axis_tdata and the buffer's final byte
// is marked by s_axis_tlast. Each buffer holds one frame.
// The master stream returns results: tuser is the kind (payload byte, frame
// done, frame error); tdata holds the unmasked byte, the frame class and the
// decoded length; tlast marks the final result caused by one input byte.
// The first result of a byte is visible on the master side in the cycle after
// the byte is accepted if the queue was empty. The decoder takes one byte per
// cycle; a byte that causes two results (the last payload byte with its done, or
// a payload byte followed by an early-end error) leaves its second result in a
// four-entry queue, and s_axis_tready falls while fewer than two entries are free.
// When the receiver stalls, results wait in the queue and input stops once it
// fills. Reset empties the queue, returns the parser to the first header byte and
// loads the buffer capacity register with 512. The user must write the capacity
// through i_cfg_we and i_cfg_wdata only while the stream is idle (not enforced).
`default_nettype none

module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] payload_byte, [10:8] frame_class,
                                             // [26:11] payload_length, [31:27] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast
);

    localparam logic [16:0] CAP_RESET = 17'd512;

    logic [16:0] r_cap;
    logic        accept;
    logic        space;
    t_push       push;
    t_result     out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    wsfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .i_cap    (r_cap),
        .o_push   (push)
    );

    wsfd_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, out_res.payload_length, out_res.frame_class,
                           out_res.payload_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire
